FILE: design/assert_macros.svh
// Assertion macros used by the Bloom filter insert engine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define BFI_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

`define BFI_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`define BFI_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define BFI_ASSERT(lbl, expr, msg)
`define BFI_ASSERT_IMP(lbl, ante, cons, msg)
`define BFI_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

FILE: design/bfi_pkg.sv
// Types, constants and helper functions of the Bloom filter insert engine.
package bfi_pkg;

  localparam int unsigned TABLE_BITS_DEF = 32768;

  localparam logic [14:0] MOD_RESET  = 15'd9973;
  localparam logic [13:0] SUM_MAX    = 14'd16383;
  localparam int unsigned SQ_BITS    = 28;
  localparam int unsigned BCD_DIGITS = 9;
  localparam logic [4:0]  STEP_LAST  = 5'(SQ_BITS - 1);

  localparam logic OP_FEED = 1'b0;
  localparam logic OP_READ = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SQUARE,
    ST_LOOP,
    ST_INDEX,
    ST_READ,
    ST_CHECK,
    ST_RDBIT,
    ST_RDDATA,
    ST_DONE
  } state_t;

  // Four packed BCD digits to binary.
  function automatic logic [13:0] bcd4_to_bin(input logic [15:0] d);
    logic [13:0] r;
    r = 14'(d[15:12]) * 14'd1000 + 14'(d[11:8]) * 14'd100
      + 14'(d[7:4]) * 14'd10 + 14'(d[3:0]);
    return r;
  endfunction

  // One shift-and-add-3 step of binary to BCD conversion.
  function automatic logic [4*BCD_DIGITS-1:0] dabble(input logic [4*BCD_DIGITS-1:0] b,
                                                     input logic bin);
    logic [4*BCD_DIGITS-1:0] adj;
    logic [3:0] dg;
    for (int i = 0; i < BCD_DIGITS; i++) begin
      dg = b[4*i +: 4];
      if (dg >= 4'd5) begin
        dg = dg + 4'd3;
      end
      adj[4*i +: 4] = dg;
    end
    return {adj[4*BCD_DIGITS-2:0], bin};
  endfunction

endpackage

FILE: design/bloom_filter_three_hash_insert.sv
// Bloom filter insert engine: byte summing, three hashes and bit table.
//
//  channel   dir  handshake                    contents
//  s_axis    in   s_axis_tvalid/s_axis_tready  byte or read request
//  m_axis    out  m_axis_tvalid/m_axis_tready  insert indices or read bit
//  cfg       in   cfg_we                       division modulus
//
// A byte that is not last is taken in the idle state. A last byte passes the
// accept, one square, 28 steps of the shared shift loop (remainder and
// BCD digits advance one square bit per step), one index step, three
// read-modify-writes (read, then check and write) on the table and a load of
// the output register. A read passes accept, address, data and load.
// After reset the table is swept to zero, one entry per cycle;
// s_axis_tready stays low meanwhile.
// A held result in the output register does not block the next request;
// the engine stalls in its load cycle only while an older result still waits.
module bloom_filter_three_hash_insert #(
  parameter int unsigned TABLE_BITS = bfi_pkg::TABLE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // char_code[7:0], read_index[22:8], zero pad
  input  logic        s_axis_tlast,  // last_char
  input  logic        s_axis_tuser,  // operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,  // division_index[14:0], midsquare_index[28:15],
                                     // fold_index[43:29], bits_newly_set[45:44],
                                     // bit_value[46], zero pad
  input  logic        cfg_we,
  input  logic [14:0] cfg_wdata
);

  localparam int unsigned AW = $clog2(TABLE_BITS);
  localparam int unsigned BW = 4 * bfi_pkg::BCD_DIGITS;

  bfi_pkg::state_t state, state_next;

  logic [13:0]   word_sum, word_sum_next;
  logic [14:0]   modulus;
  logic [27:0]   sq, sq_next;
  logic [14:0]   rem, rem_next;
  logic [BW-1:0] bcd, bcd_next;
  logic [4:0]    step, step_next;
  logic [14:0]   div_idx, div_idx_next;
  logic [13:0]   mid_idx, mid_idx_next;
  logic [14:0]   fold_idx, fold_idx_next;
  logic [1:0]    nset, nset_next;
  logic [1:0]    k, k_next;
  logic [14:0]   ridx, ridx_next;
  logic          bitv, bitv_next;
  logic [AW-1:0] clr_cnt, clr_cnt_next;
  logic          out_valid_next;
  logic [47:0]   out_data, out_data_next;

  logic [7:0]    in_char;
  logic [14:0]   in_ridx;
  logic [14:0]   sum_wide;
  logic [13:0]   sum_sat;
  logic [15:0]   rem_sh;
  logic [15:0]   mod_ext;
  logic [3:0]    dcnt;
  logic [15:0]   mid_bcd;
  logic [14:0]   probe;
  logic [16:0]   probe_ext;
  logic [16:0]   probe_wrap;
  logic [AW-1:0] tbl_addr;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic          ram_wdata;
  logic          ram_rdata;

  assign in_char = s_axis_tdata[7:0];
  assign in_ridx = s_axis_tdata[22:8];

  assign s_axis_tready = (state == bfi_pkg::ST_IDLE);
  assign m_axis_tdata  = out_data;

  assign sum_wide = {1'b0, word_sum} + 15'(in_char);
  assign sum_sat  = (sum_wide > 15'(bfi_pkg::SUM_MAX)) ? bfi_pkg::SUM_MAX : sum_wide[13:0];

  assign rem_sh  = {rem, sq[27]};
  assign mod_ext = {1'b0, modulus};

  // Table probe: pick the index, fold it into the table range.
  always_comb begin
    if (state == bfi_pkg::ST_RDBIT) begin
      probe = ridx;
    end else begin
      unique case (k)
        2'd1:    probe = {1'b0, mid_idx};
        2'd2:    probe = fold_idx;
        default: probe = div_idx;
      endcase
    end
  end

  assign probe_ext  = {2'b00, probe};
  assign probe_wrap = (probe_ext >= 17'(TABLE_BITS)) ? probe_ext - 17'(TABLE_BITS) : probe_ext;
  assign tbl_addr   = probe_wrap[AW-1:0];

  // Decimal digit count and mid-square digit pick.
  always_comb begin
    dcnt = 4'd1;
    for (int i = 1; i < bfi_pkg::BCD_DIGITS; i++) begin
      if (bcd[4*i +: 4] != 4'd0) begin
        dcnt = 4'(i + 1);
      end
    end
    unique case (dcnt)
      4'd5:    mid_bcd = {4'd0, bcd[15:4]};
      4'd6:    mid_bcd = bcd[19:4];
      4'd7:    mid_bcd = {4'd0, bcd[19:8]};
      4'd8:    mid_bcd = bcd[23:8];
      4'd9:    mid_bcd = {4'd0, bcd[23:12]};
      default: mid_bcd = bcd[15:0];
    endcase
  end

  always_comb begin
    state_next     = state;
    word_sum_next  = word_sum;
    sq_next        = sq;
    rem_next       = rem;
    bcd_next       = bcd;
    step_next      = step;
    div_idx_next   = div_idx;
    mid_idx_next   = mid_idx;
    fold_idx_next  = fold_idx;
    nset_next      = nset;
    k_next         = k;
    ridx_next      = ridx;
    bitv_next      = bitv;
    clr_cnt_next   = clr_cnt;
    out_data_next  = out_data;
    out_valid_next = m_axis_tvalid && !m_axis_tready;
    ram_we         = 1'b0;
    ram_waddr      = tbl_addr;
    ram_wdata      = 1'b1;

    unique case (state)
      bfi_pkg::ST_CLEAR: begin
        ram_we       = 1'b1;
        ram_waddr    = clr_cnt;
        ram_wdata    = 1'b0;
        clr_cnt_next = clr_cnt + AW'(1);
        if (clr_cnt == AW'(TABLE_BITS - 1)) begin
          state_next = bfi_pkg::ST_IDLE;
        end
      end
      bfi_pkg::ST_IDLE: begin
        if (s_axis_tvalid) begin
          if (s_axis_tuser == bfi_pkg::OP_READ) begin
            ridx_next  = in_ridx;
            state_next = bfi_pkg::ST_RDBIT;
          end else begin
            word_sum_next = sum_sat;
            if (s_axis_tlast) begin
              state_next = bfi_pkg::ST_SQUARE;
            end
          end
        end
      end
      bfi_pkg::ST_SQUARE: begin
        sq_next       = 28'(word_sum) * 28'(word_sum);
        word_sum_next = '0;
        rem_next      = '0;
        bcd_next      = '0;
        step_next     = '0;
        state_next    = bfi_pkg::ST_LOOP;
      end
      bfi_pkg::ST_LOOP: begin
        rem_next  = (rem_sh >= mod_ext) ? 15'(rem_sh - mod_ext) : rem_sh[14:0];
        bcd_next  = bfi_pkg::dabble(bcd, sq[27]);
        sq_next   = {sq[26:0], 1'b0};
        step_next = step + 5'd1;
        if (step == bfi_pkg::STEP_LAST) begin
          state_next = bfi_pkg::ST_INDEX;
        end
      end
      bfi_pkg::ST_INDEX: begin
        div_idx_next  = (modulus == 15'd0) ? 15'd0 : rem;
        mid_idx_next  = bfi_pkg::bcd4_to_bin(mid_bcd);
        fold_idx_next = 15'(bfi_pkg::bcd4_to_bin(bcd[15:0]))
                      + 15'(bfi_pkg::bcd4_to_bin(bcd[31:16]))
                      + 15'(bcd[35:32]);
        nset_next     = '0;
        k_next        = '0;
        bitv_next     = 1'b0;
        state_next    = bfi_pkg::ST_READ;
      end
      bfi_pkg::ST_READ: begin
        state_next = bfi_pkg::ST_CHECK;
      end
      bfi_pkg::ST_CHECK: begin
        ram_we = 1'b1;
        if (!ram_rdata) begin
          nset_next = nset + 2'd1;
        end
        if (k == 2'd2) begin
          state_next = bfi_pkg::ST_DONE;
        end else begin
          k_next     = k + 2'd1;
          state_next = bfi_pkg::ST_READ;
        end
      end
      bfi_pkg::ST_RDBIT: begin
        state_next = bfi_pkg::ST_RDDATA;
      end
      bfi_pkg::ST_RDDATA: begin
        bitv_next     = ram_rdata;
        div_idx_next  = '0;
        mid_idx_next  = '0;
        fold_idx_next = '0;
        nset_next     = '0;
        state_next    = bfi_pkg::ST_DONE;
      end
      bfi_pkg::ST_DONE: begin
        if (!m_axis_tvalid || m_axis_tready) begin
          out_valid_next = 1'b1;
          out_data_next  = {1'b0, bitv, nset, fold_idx, mid_idx, div_idx};
          state_next     = bfi_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = bfi_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= bfi_pkg::ST_CLEAR;
      word_sum      <= '0;
      modulus       <= bfi_pkg::MOD_RESET;
      clr_cnt       <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state         <= state_next;
      word_sum      <= word_sum_next;
      clr_cnt       <= clr_cnt_next;
      m_axis_tvalid <= out_valid_next;
      if (cfg_we) begin
        modulus <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    sq       <= sq_next;
    rem      <= rem_next;
    bcd      <= bcd_next;
    step     <= step_next;
    div_idx  <= div_idx_next;
    mid_idx  <= mid_idx_next;
    fold_idx <= fold_idx_next;
    nset     <= nset_next;
    k        <= k_next;
    ridx     <= ridx_next;
    bitv     <= bitv_next;
    out_data <= out_data_next;
  end

  bfi_ram #(
    .WIDTH (1),
    .DEPTH (TABLE_BITS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (tbl_addr),
    .rdata (ram_rdata)
  );

`include "assert_macros.svh"

  `BFI_ASSERT_IMP(a_out_from_done, $rose(m_axis_tvalid), $past(state == bfi_pkg::ST_DONE), "result raised outside done state")
  `BFI_ASSERT_NXT(a_loop_exit, (state == bfi_pkg::ST_LOOP) && (step == bfi_pkg::STEP_LAST), state == bfi_pkg::ST_INDEX, "shift loop did not end after last step")
  `BFI_ASSERT_IMP(a_sum_cleared, state == bfi_pkg::ST_INDEX, word_sum == 14'd0, "word sum not cleared at insert")
  `BFI_ASSERT_IMP(a_read_fields, m_axis_tvalid && m_axis_tdata[46], m_axis_tdata[45:0] == 46'd0, "read result carries insert fields")
  `BFI_ASSERT_IMP(a_clear_quiet, state == bfi_pkg::ST_CLEAR, !m_axis_tvalid, "result during table clear")

endmodule

FILE: design/bfi_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module bfi_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sim/bloom_filter_three_hash_insert_tb.sv
// Self-checking testbench for the three-hash Bloom filter insert engine.
`timescale 1ns / 100ps

module bloom_filter_three_hash_insert_tb;

  localparam int unsigned TABLE_SIZE = bfi_pkg::TABLE_BITS_DEF;
  localparam int unsigned SUM_LIMIT  = 16383;
  localparam int unsigned MAX_GAP    = 18;
  localparam int unsigned SETTLE     = 50;

  typedef struct packed {
    logic [14:0] div_idx;
    logic [13:0] mid_idx;
    logic [14:0] fold_idx;
    logic [1:0]  newly_set;
    logic        bit_val;
  } bloom_result_t;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;   // char_code[7:0], read_index[22:8], zero pad
  logic        s_axis_tlast;   // last_char
  logic        s_axis_tuser;   // operation
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;   // division_index[14:0], midsquare_index[28:15],
                               // fold_index[43:29], bits_newly_set[45:44],
                               // bit_value[46], zero pad
  logic        cfg_we;
  logic [14:0] cfg_wdata;

  bit            shadow_table [TABLE_SIZE];
  int unsigned   shadow_sum = 0;
  int unsigned   shadow_modulus = bfi_pkg::MOD_RESET;
  bloom_result_t expected_results [$];
  int unsigned   recent_indices [$];
  int unsigned   requests_sent = 0;
  int unsigned   mismatch_count = 0;
  int unsigned   stall_request = 0;
  bit            src_idle_en = 1'b1;
  bit            snk_idle_en = 1'b1;

  bloom_filter_three_hash_insert dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10ms;
    $display("Test completed with failures");
    $finish;
  end

  function automatic int unsigned decimal_digits(input int unsigned v);
    int unsigned d;
    d = 1;
    while (v >= 10) begin
      v = v / 10;
      d++;
    end
    return d;
  endfunction

  function automatic int unsigned pow_ten(input int unsigned e);
    int unsigned r;
    r = 1;
    repeat (e) r = r * 10;
    return r;
  endfunction

  function automatic int unsigned midsquare_of(input int unsigned sq);
    int unsigned d;
    d = decimal_digits(sq);
    if (d <= 4) begin
      return sq;
    end
    if (d % 2 == 0) begin
      return (sq / pow_ten(d / 2 - 2)) % 10000;
    end
    return (sq / pow_ten((d - 3) / 2)) % 1000;
  endfunction

  function automatic int unsigned fold_of(input int unsigned sq);
    int unsigned s;
    s = 0;
    while (sq > 0) begin
      s = s + sq % 10000;
      sq = sq / 10000;
    end
    return s;
  endfunction

  function automatic int unsigned mark_table_bit(input int unsigned idx);
    int unsigned a;
    a = idx % TABLE_SIZE;
    if (shadow_table[a]) begin
      return 0;
    end
    shadow_table[a] = 1'b1;
    return 1;
  endfunction

  task automatic predict_request(input logic op, input logic [7:0] ch, input logic last,
                                 input logic [14:0] ridx);
    bloom_result_t r;
    int unsigned   sq;
    int unsigned   di;
    int unsigned   mi;
    int unsigned   fi;
    int unsigned   n;
    r = '0;
    if (op == bfi_pkg::OP_READ) begin
      r.bit_val = shadow_table[ridx % TABLE_SIZE];
      expected_results.push_back(r);
      return;
    end
    shadow_sum = shadow_sum + ch;
    if (shadow_sum > SUM_LIMIT) begin
      shadow_sum = SUM_LIMIT;
    end
    if (!last) begin
      return;
    end
    sq = shadow_sum * shadow_sum;
    di = (shadow_modulus == 0) ? 0 : sq % shadow_modulus;
    mi = midsquare_of(sq);
    fi = fold_of(sq);
    n = mark_table_bit(di);
    n = n + mark_table_bit(mi);
    n = n + mark_table_bit(fi);
    r.div_idx   = di[14:0];
    r.mid_idx   = mi[13:0];
    r.fold_idx  = fi[14:0];
    r.newly_set = n[1:0];
    expected_results.push_back(r);
    recent_indices.push_back(di);
    recent_indices.push_back(mi);
    recent_indices.push_back(fi);
    while (recent_indices.size() > 64) begin
      void'(recent_indices.pop_front());
    end
    shadow_sum = 0;
  endtask

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    mismatch_count++;
    $display("%0t: %s mismatch, got %0d, expected %0d", $time, what, got, want);
  endtask

  task automatic check_result(input logic [47:0] d);
    bloom_result_t want;
    if (expected_results.size() == 0) begin
      report_mismatch("unexpected result", d[31:0], 0);
      return;
    end
    want = expected_results.pop_front();
    if (d[14:0] !== want.div_idx)
      report_mismatch("division_index", d[14:0], want.div_idx);
    if (d[28:15] !== want.mid_idx)
      report_mismatch("midsquare_index", d[28:15], want.mid_idx);
    if (d[43:29] !== want.fold_idx)
      report_mismatch("fold_index", d[43:29], want.fold_idx);
    if (d[45:44] !== want.newly_set)
      report_mismatch("bits_newly_set", d[45:44], want.newly_set);
    if (d[46] !== want.bit_val)
      report_mismatch("bit_value", d[46], want.bit_val);
  endtask

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      check_result(m_axis_tdata);
    end
  end

  initial begin : result_sink
    int unsigned gap;
    m_axis_tready <= 1'b0;
    @(posedge clk);
    forever begin
      if (stall_request > 0) begin
        gap = stall_request;
        stall_request = 0;
      end else begin
        gap = snk_idle_en ? $urandom_range(0, MAX_GAP) : 0;
      end
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!(m_axis_tvalid && m_axis_tready));
    end
  end

  task automatic send_item(input logic op, input logic [7:0] ch, input logic last,
                           input logic [14:0] ridx);
    int unsigned gap;
    gap = src_idle_en ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, ridx, ch};
    s_axis_tlast  <= last;
    s_axis_tuser  <= op;
    do @(posedge clk); while (!s_axis_tready);
    predict_request(op, ch, last, ridx);
    requests_sent++;
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_modulus(input logic [14:0] value);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    shadow_modulus = value;
  endtask

  task automatic send_random_read();
    logic [14:0] idx;
    if (recent_indices.size() > 0 && $urandom_range(0, 1) == 0) begin
      idx = 15'(recent_indices[$urandom_range(0, recent_indices.size() - 1)]);
    end else begin
      idx = 15'($urandom());
    end
    send_item(bfi_pkg::OP_READ, 8'($urandom()), 1'($urandom()), idx);
  endtask

  task automatic send_random_word();
    int unsigned kind;
    int unsigned len;
    int unsigned lo;
    int unsigned hi;
    kind = $urandom_range(0, 19);
    if (kind == 0) begin
      len = $urandom_range(40, 80);
      lo  = 150;
      hi  = 255;
    end else if (kind <= 3) begin
      len = $urandom_range(1, 2);
      lo  = 0;
      hi  = 12;
    end else begin
      len = $urandom_range(1, 12);
      lo  = 0;
      hi  = 255;
    end
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 5) == 0) begin
        send_random_read();
      end
      send_item(bfi_pkg::OP_FEED, 8'($urandom_range(lo, hi)), i == len - 1,
                15'($urandom()));
    end
  endtask

  task automatic run_traffic(input int unsigned count);
    int unsigned start;
    start = requests_sent;
    while (requests_sent - start < count) begin
      send_random_word();
    end
  endtask

  task automatic test_directed();
    send_item(bfi_pkg::OP_READ, 8'hFF, 1'b1, 15'd0);
    send_item(bfi_pkg::OP_READ, 8'h00, 1'b0, 15'h7FFF);
    // zero square, all three indices collide at 0
    send_item(bfi_pkg::OP_FEED, 8'd0, 1'b1, 15'h7FFF);
    send_item(bfi_pkg::OP_READ, 8'h00, 1'b0, 15'd0);
    send_item(bfi_pkg::OP_FEED, 8'd5, 1'b1, 15'h2AAA);
    send_item(bfi_pkg::OP_READ, 8'h5A, 1'b1, 15'd25);
    send_item(bfi_pkg::OP_FEED, 8'd255, 1'b1, 15'h5555);
    send_item(bfi_pkg::OP_READ, 8'h00, 1'b0, 15'd502);
    send_item(bfi_pkg::OP_FEED, 8'd255, 1'b0, 15'd0);
    send_item(bfi_pkg::OP_FEED, 8'd255, 1'b0, 15'd0);
    // read inside a word: byte and last flag are ignored, sum is kept
    send_item(bfi_pkg::OP_READ, 8'hFF, 1'b1, 15'd25);
    send_item(bfi_pkg::OP_FEED, 8'd255, 1'b0, 15'd0);
    send_item(bfi_pkg::OP_FEED, 8'd255, 1'b1, 15'd0);
    send_item(bfi_pkg::OP_FEED, 8'd200, 1'b0, 15'h7FFF);
    send_item(bfi_pkg::OP_FEED, 8'd200, 1'b1, 15'h7FFF);
    send_item(bfi_pkg::OP_READ, 8'h00, 1'b0, 15'h7FFF);
  endtask

  task automatic test_modulus_extremes();
    write_modulus(15'd1);
    run_traffic(100);
    write_modulus(15'h7FFF);
    run_traffic(100);
    write_modulus(15'd0);
    run_traffic(100);
  endtask

  task automatic test_output_stall();
    drain_results();
    src_idle_en = 1'b0;
    stall_request = 400;
    for (int i = 0; i < 15; i++) begin
      send_random_read();
      send_item(bfi_pkg::OP_FEED, 8'($urandom()), 1'b1, 15'($urandom()));
    end
    src_idle_en = 1'b1;
  endtask

  task automatic test_random_traffic();
    for (int p = 0; p < 6; p++) begin
      src_idle_en = (p % 2 == 0);
      snk_idle_en = (p % 3 != 2);
      write_modulus(p < 5 ? 15'($urandom_range(1, 32767)) : bfi_pkg::MOD_RESET);
      run_traffic(180);
    end
    src_idle_en = 1'b1;
    snk_idle_en = 1'b1;
  endtask

  initial begin
    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tlast  <= 1'b0;
    s_axis_tuser  <= bfi_pkg::OP_FEED;
    cfg_we        <= 1'b0;
    cfg_wdata     <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_modulus_extremes();
    test_output_stall();
    test_random_traffic();
    drain_results();
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+design
design/bfi_pkg.sv
design/bfi_ram.sv
design/bloom_filter_three_hash_insert.sv
sim/bloom_filter_three_hash_insert_tb.sv
